// ----- hw/rtl/rbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, codes and defaults for the ring buffer deque core.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DEPTH_DEF = 64;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths
  localparam int REQ_W  = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 7;
  localparam int EXT_W  = 64;   // widest store word, used for resizing

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DATA      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data_word;
    logic              last_of_run;
  } out_beat_t;

  typedef enum logic {
    STEP_NEXT,
    STEP_PREV
  } step_dir_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_DUMP,
    S_STATUS
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ring_buffer_deque_core.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_deque_core
// Double-ended queue kept in a circular store of configurable live size.
// ----------------------------------------------------------------------------
// Takes one request beat at a time and walks it through a small sequencer
// that drives a single store port pair and one shared wrap-around index
// stepper. A push goes from decode back to idle, with no result; a pop via
// decode and the pop state; an overflow, an underflow or an empty dump via
// decode and the status state; a dump emits its entries in turn while the
// output is free, as the store gives one read per cycle. Output stall holds
// the sequencer. Writing capacity empties the deque at once (stored words
// stay put); capacity above MAX_DEPTH acts as MAX_DEPTH and zero makes every
// push overflow. No clearing pass after reset: ready the first cycle after rst.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque_core #(
  parameter int MAX_DEPTH = rbd_pkg::MAX_DEPTH_DEF,
  parameter int WORD_BITS = rbd_pkg::WORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire rbd_pkg::in_beat_t          in_data,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rbd_pkg::out_beat_t              out_data,
  // capacity register
  input  wire logic                       cfg_we,
  input  wire logic [rbd_pkg::CAP_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  // Control state
  rbd_pkg::state_t             state, state_next;
  logic [rbd_pkg::CAP_W-1:0]   capacity;
  logic [IDX_W-1:0]            head, head_next;
  logic [IDX_W-1:0]            tail, tail_next;
  logic [CNT_W-1:0]            count, count_next;
  logic [IDX_W-1:0]            dump_idx, dump_idx_next;
  logic [CNT_W-1:0]            remaining, remaining_next;

  // Payload holding registers
  rbd_pkg::in_beat_t           req_beat;
  logic [rbd_pkg::STAT_W-1:0]  status_code, status_next;

  // Store and stepper hookup
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [WORD_BITS-1:0]        wr_word;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [WORD_BITS-1:0]        rd_word;
  logic [rbd_pkg::EXT_W-1:0]   push_ext;
  logic [rbd_pkg::EXT_W-1:0]   rd_ext;

  logic [IDX_W-1:0]            step_idx;
  rbd_pkg::step_dir_t          step_dir;
  logic [IDX_W-1:0]            step_out;

  logic [CNT_W-1:0]            cap_live;
  logic                        is_back;
  logic                        at_rest;
  logic                        out_free;
  logic                        out_load;
  rbd_pkg::out_beat_t          out_beat_next;

  // Clamp the register to the store depth
  assign cap_live = (capacity > rbd_pkg::CAP_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH)
                                                            : CNT_W'(capacity);

  // Accept only between requests
  assign in_stall = (state != rbd_pkg::S_IDLE);

  // Output register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  // Back-end requests share one decode bit
  assign is_back = req_beat.req_type inside {rbd_pkg::REQ_PUSH_BACK, rbd_pkg::REQ_POP_BACK};

  // Empty deque with indices together: store in place, move nothing
  assign at_rest = (count == '0) && (head == tail);

  // Resize between the 32-bit fields and the store word
  assign push_ext = rbd_pkg::EXT_W'(req_beat.push_value);
  assign wr_word  = push_ext[WORD_BITS-1:0];
  assign rd_ext   = rbd_pkg::EXT_W'(rd_word);

  rbd_store #(
    .MAX_DEPTH (MAX_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  rbd_idx_step #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_step (
    .idx     (step_idx),
    .dir     (step_dir),
    .cap     (cap_live),
    .idx_out (step_out)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state, index updates, store and output control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    dump_idx_next  = dump_idx;
    remaining_next = remaining;
    status_next    = status_code;
    wr_en          = 1'b0;
    wr_addr        = tail;
    rd_en          = 1'b0;
    rd_addr        = head;
    step_idx       = tail;
    step_dir       = rbd_pkg::STEP_NEXT;
    out_load       = 1'b0;
    out_beat_next  = '0;

    case (state)
      rbd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = rbd_pkg::S_DECODE;
        end
      end

      rbd_pkg::S_DECODE: begin
        case (req_beat.req_type)
          rbd_pkg::REQ_PUSH_BACK, rbd_pkg::REQ_PUSH_FRONT: begin
            // push back steps tail forward, push front steps head back
            step_idx = is_back ? tail : head;
            step_dir = is_back ? rbd_pkg::STEP_NEXT : rbd_pkg::STEP_PREV;
            if (count >= cap_live) begin
              status_next = rbd_pkg::ST_OVERFLOW;
              state_next  = rbd_pkg::S_STATUS;
            end else begin
              wr_en   = 1'b1;
              wr_addr = at_rest ? step_idx : step_out;
              if (is_back) begin
                tail_next = wr_addr;
              end else begin
                head_next = wr_addr;
              end
              count_next = count + CNT_W'(1);
              state_next = rbd_pkg::S_IDLE;
            end
          end
          rbd_pkg::REQ_POP_BACK, rbd_pkg::REQ_POP_FRONT: begin
            if (count == '0) begin
              status_next = rbd_pkg::ST_UNDERFLOW;
              state_next  = rbd_pkg::S_STATUS;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = is_back ? tail : head;
              state_next = rbd_pkg::S_POP;
            end
          end
          rbd_pkg::REQ_DUMP: begin
            if (count == '0) begin
              status_next = rbd_pkg::ST_EMPTY;
              state_next  = rbd_pkg::S_STATUS;
            end else begin
              rd_en          = 1'b1;
              rd_addr        = head;
              dump_idx_next  = head;
              remaining_next = count;
              state_next     = rbd_pkg::S_DUMP;
            end
          end
          default: begin
            // unused codes: drop silently
            state_next = rbd_pkg::S_IDLE;
          end
        endcase
      end

      rbd_pkg::S_POP: begin
        // read data is ready; retire the end entry once the output is free
        step_idx = is_back ? tail : head;
        step_dir = is_back ? rbd_pkg::STEP_PREV : rbd_pkg::STEP_NEXT;
        if (out_free) begin
          out_load                  = 1'b1;
          out_beat_next.status      = rbd_pkg::ST_DATA;
          out_beat_next.data_word   = rd_ext[rbd_pkg::DATA_W-1:0];
          out_beat_next.last_of_run = 1'b1;
          if (is_back) begin
            tail_next = step_out;
          end else begin
            head_next = step_out;
          end
          count_next = count - CNT_W'(1);
          state_next = rbd_pkg::S_IDLE;
        end
      end

      rbd_pkg::S_DUMP: begin
        // one entry per cycle while the output is free: emit current, fetch the next
        step_idx = dump_idx;
        step_dir = rbd_pkg::STEP_NEXT;
        if (out_free) begin
          out_load                  = 1'b1;
          out_beat_next.status      = rbd_pkg::ST_DATA;
          out_beat_next.data_word   = rd_ext[rbd_pkg::DATA_W-1:0];
          out_beat_next.last_of_run = (remaining == CNT_W'(1));
          if (remaining == CNT_W'(1)) begin
            state_next = rbd_pkg::S_IDLE;
          end else begin
            rd_en          = 1'b1;
            rd_addr        = step_out;
            dump_idx_next  = step_out;
            remaining_next = remaining - CNT_W'(1);
          end
        end
      end

      rbd_pkg::S_STATUS: begin
        if (out_free) begin
          out_load                  = 1'b1;
          out_beat_next.status      = status_code;
          out_beat_next.last_of_run = 1'b1;
          state_next                = rbd_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rbd_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A capacity write empties the deque; the user must write it only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= rbd_pkg::CAP_RESET;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      dump_idx  <= '0;
      remaining <= '0;
    end else begin
      dump_idx  <= dump_idx_next;
      remaining <= remaining_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
        head     <= '0;
        tail     <= '0;
        count    <= '0;
      end else begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // Latch the request beat and any pending status code
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_beat <= in_data;
    end
    status_code <= status_next;
  end

  // Output register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_beat_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap_live)
    else $error("entry count exceeds live capacity");

  a_idx_in_cap: assert property (@(posedge clk) disable iff (rst)
    (cap_live != '0) |-> (CNT_W'(head) < cap_live) && (CNT_W'(tail) < cap_live))
    else $error("head or tail outside the live ring");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (state == rbd_pkg::S_DECODE && !cfg_we && count < cap_live &&
     (req_beat.req_type == rbd_pkg::REQ_PUSH_BACK ||
      req_beat.req_type == rbd_pkg::REQ_PUSH_FRONT))
    |=> count == $past(count) + CNT_W'(1))
    else $error("accepted push did not grow the deque by one");

  a_dump_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == rbd_pkg::S_DUMP) |-> (remaining != '0))
    else $error("dump running with nothing left");

  a_last_ends_req: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_beat_next.last_of_run) |=> (state == rbd_pkg::S_IDLE))
    else $error("final result beat did not return the sequencer to idle");

endmodule

`default_nettype wire

// ----- hw/rtl/rbd_idx_step.sv -----
// ----------------------------------------------------------------------------
// rbd_idx_step
// Shared wrap-around index stepper: one place forward or back in a ring
// whose live size is cap.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_idx_step #(
  parameter int MAX_DEPTH = rbd_pkg::MAX_DEPTH_DEF
) (
  input  wire logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0] idx,
  input  wire rbd_pkg::step_dir_t                                   dir,
  input  wire logic [$clog2(MAX_DEPTH + 1)-1:0]                      cap,
  output logic      [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0] idx_out
);

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] cap_dec;

  assign idx_ext = CNT_W'(idx);
  assign idx_inc = idx_ext + CNT_W'(1);
  assign cap_dec = cap - CNT_W'(1);

  always_comb begin
    idx_out = '0;
    case (dir)
      rbd_pkg::STEP_NEXT: begin
        // wrap to zero at the live end
        idx_out = (idx_inc >= cap) ? '0 : IDX_W'(idx_inc);
      end
      rbd_pkg::STEP_PREV: begin
        if (cap == '0) begin
          idx_out = '0;
        end else if (idx_ext == '0 || idx_ext >= cap) begin
          idx_out = IDX_W'(cap_dec);
        end else begin
          idx_out = IDX_W'(idx_ext - CNT_W'(1));
        end
      end
      default: idx_out = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rbd_store.sv -----
// ----------------------------------------------------------------------------
// rbd_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_store #(
  parameter int MAX_DEPTH = rbd_pkg::MAX_DEPTH_DEF,
  parameter int WORD_BITS = rbd_pkg::WORD_BITS_DEF
) (
  input  wire logic                                                  clk,
  input  wire logic                                                  wr_en,
  input  wire logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WORD_BITS-1:0]                                  wr_data,
  input  wire logic                                                  rd_en,
  input  wire logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0] rd_addr,
  output logic      [WORD_BITS-1:0]                                  rd_data
);

  logic [WORD_BITS-1:0] mem [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
